/* sv/cltc_pkg.sv */
`default_nettype none
package cltc_pkg;

    typedef enum logic [3:0] {
        REQ_LOOKUP       = 4'd0,
        REQ_GRANT        = 4'd1,
        REQ_TRY_GRANT    = 4'd2,
        REQ_EXPIRE       = 4'd3,
        REQ_EXPIRE_OWNER = 4'd4,
        REQ_REAP         = 4'd5,
        REQ_LIVE_COUNT   = 4'd6,
        REQ_READ_NTH     = 4'd7,
        REQ_CLEAR        = 4'd8
    } req_kind_t;

    localparam logic [63:0] NS_PER_SECOND = 64'd1000000000;
    localparam logic [6:0]  CAP_LIMIT_RESET = 7'd64;
    localparam logic [1:0]  REG_CAP_LIMIT = 2'd0;

    typedef struct packed {
        logic [3:0]  req_type;
        logic [63:0] owner_id;
        logic [5:0]  cap_code;
        logic [31:0] lifetime_s;
        logic [63:0] now_time;
        logic        authority_ok;
        logic [7:0]  nth_index;
    } req_item_t;

    typedef struct packed {
        logic        ok;
        logic [4:0]  row_count;
        logic [63:0] out_owner;
        logic [5:0]  out_cap;
        logic [63:0] out_deadline;
        logic [63:0] out_generation;
    } rsp_item_t;

endpackage
`default_nettype wire

/* sv/capability_lease_ttl_cache_core.sv */
// Lease table with timed rows and earliest-deadline eviction.
// Requests arrive on the req channel (req_valid/req_stall/req_data) and one
// result item per request leaves on the rsp channel (rsp_valid/rsp_stall/
// rsp_data). The block handles one item at a time: req_stall is high from
// acceptance until its result has been taken.
// One pass over the rows reaps expired rows and a second pass matches, counts
// or picks a victim, one row per cycle through a single shared compare unit.
// Reap requests end after the first pass. A grant adds a lifetime multiply
// step before the passes and a row write step after them. Requests that do
// not reap (expire, expire_owner, clear) use one pass. Rejected requests
// answer in the cycle after acceptance.
// The result sits in an output register until rsp_stall is low; no new item
// is taken meanwhile.
// Reset empties the table, sets the generation counter to one and
// cap_limit to 64. cap_limit is written over the APB port at address 0.
`default_nettype none
module capability_lease_ttl_cache_core
    import cltc_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_stall,
    input  wire req_item_t req_data,
    output logic           rsp_valid,
    input  wire logic      rsp_stall,
    output rsp_item_t      rsp_data,
    input  wire logic      psel,
    input  wire logic      penable,
    input  wire logic      pwrite,
    input  wire logic [1:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_REAP, S_SCAN, S_WRITE, S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic [6:0] cap_limit_reg;

    logic [ENTRIES-1:0] row_valid_reg;
    logic [63:0] row_owner_reg [ENTRIES];
    logic [5:0]  row_cap_reg   [ENTRIES];
    logic [63:0] row_exp_reg   [ENTRIES];
    logic [63:0] row_gen_reg   [ENTRIES];
    logic [63:0] next_gen_reg;

    req_item_t  req_reg;
    rsp_item_t  rsp_reg;
    logic [IW-1:0] idx_reg;
    logic [CW-1:0] cnt_reg;
    logic [63:0]   deadline_reg;
    logic          found_reg;
    logic [IW-1:0] hit_reg;
    logic          free_reg;
    logic [IW-1:0] free_idx_reg;
    logic [IW-1:0] vic_reg;
    logic [63:0]   vic_exp_reg;

    logic          last;
    logic          cur_v;
    logic          expired;
    logic          live;
    logic          own_eq;
    logic          match;
    logic          cap_ok;
    logic [63:0]   now;
    logic [4:0]    cnt_sat;
    logic [IW-1:0] slot;
    logic [63:0]   gen_take;
    logic [63:0]   gen_after;
    logic [63:0]   grant_deadline;
    logic          grant_wrap;

    assign now     = req_reg.now_time;
    assign last    = (idx_reg == IW'(ENTRIES - 1));
    assign cur_v   = row_valid_reg[idx_reg];
    assign expired = cur_v && (now == 64'd0 || row_exp_reg[idx_reg] <= now);
    assign live    = cur_v && (now < row_exp_reg[idx_reg]);
    assign own_eq  = (row_owner_reg[idx_reg] == req_reg.owner_id);
    assign match   = own_eq && (row_cap_reg[idx_reg] == req_reg.cap_code);
    assign cap_ok  = (req_data.cap_code != 6'd0) &&
                     ({1'b0, req_data.cap_code} < cap_limit_reg);
    assign cnt_sat = (CW > 5 && cnt_reg > CW'(31)) ? 5'd31 : 5'(cnt_reg);
    assign slot    = found_reg ? hit_reg : (free_reg ? free_idx_reg : vic_reg);
    assign gen_take  = (next_gen_reg == 64'd0) ? 64'd1 : next_gen_reg;
    assign gen_after = gen_take + 64'd1;
    // 32x30-bit product fits easily; wrap check on the sum.
    assign grant_deadline = req_reg.now_time +
                            ({32'd0, req_reg.lifetime_s} * NS_PER_SECOND);
    assign grant_wrap     = (grant_deadline <= req_reg.now_time);

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = (state_reg == S_DONE);
    assign rsp_data  = rsp_reg;
    assign pready    = 1'b1;
    assign prdata    = {25'd0, cap_limit_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    priority case (req_data.req_type)
                        REQ_LOOKUP, REQ_TRY_GRANT:
                            state_next = cap_ok ? S_REAP : S_DONE;
                        REQ_GRANT:
                            state_next = (cap_ok && req_data.lifetime_s != 32'd0 &&
                                          req_data.now_time != 64'd0) ? S_MUL : S_DONE;
                        REQ_EXPIRE:
                            state_next = cap_ok ? S_SCAN : S_DONE;
                        REQ_EXPIRE_OWNER, REQ_CLEAR:
                            state_next = S_SCAN;
                        REQ_REAP, REQ_LIVE_COUNT, REQ_READ_NTH:
                            state_next = S_REAP;
                        default:
                            state_next = S_DONE;
                    endcase
                end
            end
            S_MUL:   state_next = grant_wrap ? S_DONE : S_REAP;
            S_REAP:  state_next = last ? (req_reg.req_type == REQ_REAP ? S_DONE : S_SCAN)
                                       : S_REAP;
            S_SCAN:  state_next = last ? (req_reg.req_type == REQ_GRANT ? S_WRITE : S_DONE)
                                       : S_SCAN;
            S_WRITE: state_next = S_DONE;
            S_DONE:  state_next = rsp_stall ? S_DONE : S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cap_limit_reg <= CAP_LIMIT_RESET;
            row_valid_reg <= '0;
            next_gen_reg  <= 64'd1;
        end
        else
        begin
            state_reg <= state_next;
            if (psel && penable && pwrite && paddr == REG_CAP_LIMIT)
            begin
                cap_limit_reg <= pwdata[6:0];
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        req_reg   <= req_data;
                        rsp_reg   <= '0;
                        idx_reg   <= '0;
                        cnt_reg   <= '0;
                        found_reg <= 1'b0;
                        free_reg  <= 1'b0;
                        hit_reg   <= '0;
                        free_idx_reg <= '0;
                        vic_reg   <= '0;
                        vic_exp_reg <= row_exp_reg[0];
                    end
                end
                S_MUL:
                begin
                    deadline_reg <= grant_deadline;
                end
                S_REAP:
                begin
                    idx_reg <= last ? '0 : idx_reg + IW'(1);
                    if (expired)
                    begin
                        row_valid_reg[idx_reg] <= 1'b0;
                        row_owner_reg[idx_reg] <= '0;
                        row_cap_reg[idx_reg]   <= '0;
                        row_exp_reg[idx_reg]   <= '0;
                        row_gen_reg[idx_reg]   <= '0;
                    end
                    if (last)
                    begin
                        cnt_reg <= '0;
                    end
                    else if (expired)
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                    if (last)
                    begin
                        if (req_reg.req_type == REQ_REAP)
                        begin
                            rsp_reg.row_count <= (CW > 5 && (cnt_reg + CW'(expired)) > CW'(31))
                                ? 5'd31 : 5'(cnt_reg + CW'(expired));
                        end
                        // Row 0 may have just been wiped; the victim seed
                        // must follow the table after reaping.
                        vic_exp_reg <= (expired && idx_reg == '0) ? 64'd0 : row_exp_reg[0];
                    end
                end
                S_SCAN:
                begin
                    idx_reg <= last ? '0 : idx_reg + IW'(1);
                    priority case (req_reg.req_type)
                        REQ_LOOKUP, REQ_GRANT, REQ_TRY_GRANT:
                        begin
                            if (!found_reg && live && match)
                            begin
                                found_reg <= 1'b1;
                                hit_reg   <= idx_reg;
                            end
                            if (!free_reg && !cur_v)
                            begin
                                free_reg     <= 1'b1;
                                free_idx_reg <= idx_reg;
                            end
                            if (row_exp_reg[idx_reg] < vic_exp_reg)
                            begin
                                vic_exp_reg <= row_exp_reg[idx_reg];
                                vic_reg     <= idx_reg;
                            end
                        end
                        REQ_EXPIRE, REQ_EXPIRE_OWNER, REQ_CLEAR:
                        begin
                            if (req_reg.req_type == REQ_CLEAR ||
                                (cur_v && own_eq &&
                                 (req_reg.req_type == REQ_EXPIRE_OWNER || match)))
                            begin
                                row_valid_reg[idx_reg] <= 1'b0;
                                row_owner_reg[idx_reg] <= '0;
                                row_cap_reg[idx_reg]   <= '0;
                                row_exp_reg[idx_reg]   <= '0;
                                row_gen_reg[idx_reg]   <= '0;
                            end
                        end
                        REQ_LIVE_COUNT:
                        begin
                            if (live)
                            begin
                                cnt_reg <= cnt_reg + CW'(1);
                            end
                        end
                        REQ_READ_NTH:
                        begin
                            if (live)
                            begin
                                cnt_reg <= cnt_reg + CW'(1);
                                if (!found_reg &&
                                    (CW+8)'(cnt_reg) == (CW+8)'(req_reg.nth_index))
                                begin
                                    found_reg <= 1'b1;
                                    rsp_reg.ok <= 1'b1;
                                    rsp_reg.out_owner      <= row_owner_reg[idx_reg];
                                    rsp_reg.out_cap        <= row_cap_reg[idx_reg];
                                    rsp_reg.out_deadline   <= row_exp_reg[idx_reg];
                                    rsp_reg.out_generation <= row_gen_reg[idx_reg];
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    if (last && req_reg.req_type == REQ_LIVE_COUNT)
                    begin
                        rsp_reg.row_count <= (CW > 5 && (cnt_reg + CW'(live)) > CW'(31))
                            ? 5'd31 : 5'(cnt_reg + CW'(live));
                    end
                    if (last && (req_reg.req_type == REQ_LOOKUP ||
                                 req_reg.req_type == REQ_TRY_GRANT))
                    begin
                        // Final hit decision includes the last row.
                        if (found_reg || (live && match))
                        begin
                            if (req_reg.req_type == REQ_LOOKUP || req_reg.authority_ok)
                            begin
                                rsp_reg.ok <= 1'b1;
                                rsp_reg.out_deadline <=
                                    row_exp_reg[found_reg ? hit_reg : idx_reg];
                                rsp_reg.out_generation <=
                                    row_gen_reg[found_reg ? hit_reg : idx_reg];
                            end
                            else
                            begin
                                row_valid_reg[found_reg ? hit_reg : idx_reg] <= 1'b0;
                                row_owner_reg[found_reg ? hit_reg : idx_reg] <= '0;
                                row_cap_reg[found_reg ? hit_reg : idx_reg]   <= '0;
                                row_exp_reg[found_reg ? hit_reg : idx_reg]   <= '0;
                                row_gen_reg[found_reg ? hit_reg : idx_reg]   <= '0;
                            end
                        end
                    end
                end
                S_WRITE:
                begin
                    next_gen_reg <= gen_after;
                    if (req_reg.authority_ok)
                    begin
                        row_valid_reg[slot] <= 1'b1;
                        row_owner_reg[slot] <= req_reg.owner_id;
                        row_cap_reg[slot]   <= req_reg.cap_code;
                        row_exp_reg[slot]   <= deadline_reg;
                        row_gen_reg[slot]   <= gen_take;
                        rsp_reg.ok             <= 1'b1;
                        rsp_reg.out_deadline   <= deadline_reg;
                        rsp_reg.out_generation <= gen_take;
                    end
                end
                S_DONE:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    logic unused_ok;
    assign unused_ok = ^{cnt_sat, pwdata[31:7]};

    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> req_stall)
        else $error("result shown while accepting items");
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
        else $error("stalled result changed");
    a_gen_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE && req_reg.authority_ok) |=> rsp_data.out_generation != 64'd0)
        else $error("granted generation zero");

endmodule
`default_nettype wire
